>>> sv/gb3_pkg.sv
// shared types and constants of the 3x3 binomial blur core
// no dependencies; imported by every module of the core but gb3_fifo
package gb3_pkg;

  // default frame limits
  localparam int GB3_MAX_WIDTH  = 2048;
  localparam int GB3_MAX_HEIGHT = 4096;

  // configuration register widths and reset values
  localparam int GB3_W_REG_W    = 12;
  localparam int GB3_H_REG_W    = 13;
  localparam int GB3_CFG_DW     = 13;
  localparam int GB3_RST_WIDTH  = 640;
  localparam int GB3_RST_HEIGHT = 480;

  // queue depths between the parts
  localparam int GB3_JOB_DEPTH = 4;
  localparam int GB3_JOB_CNT_W = $clog2(GB3_JOB_DEPTH) + 1;
  localparam int GB3_OUT_DEPTH = 2;
  localparam int GB3_OUT_CNT_W = $clog2(GB3_OUT_DEPTH) + 1;

  // register indexes of the configuration port
  typedef enum logic {
    GB3_REG_WIDTH  = 1'b0,
    GB3_REG_HEIGHT = 1'b1
  } gb3_reg_e;

  // 3x3 window, index row*3+col, row 0 oldest, col 2 newest
  typedef logic [8:0][7:0] gb3_win_t;

  // position flags of one pixel
  typedef struct packed {
    logic i_ge1;
    logic i_ge2;
    logic last_row;
    logic j_ge1;
    logic j_ge2;
    logic last_col;
  } gb3_flags_t;

  // work handed from front to back: window after the pixel plus its flags
  typedef struct packed {
    gb3_win_t   win;
    gb3_flags_t flags;
  } gb3_job_t;

  // one result
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       done;
  } gb3_res_t;

endpackage

>>> sv/gb3_fifo.sv
// small register queue used for jobs and for results
// depends on nothing but its parameters
module gb3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH):0]     count_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != (AW+1)'(DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

>>> sv/gb3_front.sv
// front part: config registers, raster position, line stores and window
// depends on gb3_pkg; pushes one job per accepted pixel
module gb3_front #(
  parameter int MAX_WIDTH  = gb3_pkg::GB3_MAX_WIDTH,
  parameter int MAX_HEIGHT = gb3_pkg::GB3_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  gb3_pkg::gb3_reg_e                 cfg_idx_i,
  input  logic [gb3_pkg::GB3_CFG_DW-1:0]    cfg_data_i,
  input  logic                              push,
  input  logic [7:0]                        pixel_value_i,
  output logic                              full,
  input  logic [gb3_pkg::GB3_JOB_CNT_W-1:0] job_cnt_i,
  output logic                              job_push_o,
  output gb3_pkg::gb3_job_t                 job_o
);

  import gb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int RST_W_LAST =
    ((GB3_RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : GB3_RST_WIDTH) - 1;
  localparam int RST_H_LAST =
    ((GB3_RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : GB3_RST_HEIGHT) - 1;

  // line stores: upper byte is the row two above, lower byte the row above
  logic [15:0]   line_mem [MAX_WIDTH];

  logic [CW-1:0] w_last_q, w_last_d;
  logic [RW-1:0] h_last_q, h_last_d;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          valid_a_q;
  logic [7:0]    pix_a_q;
  logic [CW-1:0] idx_a_q;
  gb3_flags_t    flags_a_q, flags_d;
  logic [15:0]   rd_q;
  logic          fwd_q;
  logic [15:0]   fwd_data_q;
  gb3_win_t      win_q, win_d;
  logic [31:0]   wv, hv;
  logic          accept, last_col, last_row;
  logic [7:0]    older_pix, newer_pix;
  logic [15:0]   wr_data;

  // conservative credit check: a pixel in flight always finds room
  assign full   = ({1'b0, job_cnt_i} + (GB3_JOB_CNT_W+1)'(valid_a_q))
                  >= (GB3_JOB_CNT_W+1)'(GB3_JOB_DEPTH);
  assign accept = push && !full;

  assign last_col = (col_q >= w_last_q);
  assign last_row = (row_q >= h_last_q);

  // effective last column and row from the written size
  always_comb begin
    wv       = 32'(cfg_data_i[GB3_W_REG_W-1:0]);
    hv       = 32'(cfg_data_i[GB3_H_REG_W-1:0]);
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        GB3_REG_WIDTH: begin
          if (wv == 32'd0) begin
            w_last_d = '0;
          end else if (wv > 32'(MAX_WIDTH)) begin
            w_last_d = CW'(MAX_WIDTH - 1);
          end else begin
            w_last_d = CW'(wv - 32'd1);
          end
        end
        GB3_REG_HEIGHT: begin
          if (hv == 32'd0) begin
            h_last_d = '0;
          end else if (hv > 32'(MAX_HEIGHT)) begin
            h_last_d = RW'(MAX_HEIGHT - 1);
          end else begin
            h_last_d = RW'(hv - 32'd1);
          end
        end
        default: begin
          w_last_d = w_last_q;
          h_last_d = h_last_q;
        end
      endcase
    end
  end

  // flags of the incoming pixel
  always_comb begin
    flags_d.i_ge1    = (row_q != '0);
    flags_d.i_ge2    = (row_q >= RW'(2));
    flags_d.last_row = last_row;
    flags_d.j_ge1    = (col_q != '0);
    flags_d.j_ge2    = (col_q >= CW'(2));
    flags_d.last_col = last_col;
  end

  // config, raster position and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q  <= CW'(RST_W_LAST);
      h_last_q  <= RW'(RST_H_LAST);
      col_q     <= '0;
      row_q     <= '0;
      valid_a_q <= 1'b0;
    end else begin
      w_last_q  <= w_last_d;
      h_last_q  <= h_last_d;
      valid_a_q <= accept;
      if (accept) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  // new window column, forwarding a pending line store write to the same column
  assign older_pix = fwd_q ? fwd_data_q[15:8] : rd_q[15:8];
  assign newer_pix = fwd_q ? fwd_data_q[7:0]  : rd_q[7:0];
  assign wr_data   = {newer_pix, pix_a_q};

  // line store read at accept, write back in the following cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q       <= line_mem[col_q];
      fwd_q      <= valid_a_q && (idx_a_q == col_q);
      fwd_data_q <= wr_data;
      pix_a_q    <= pixel_value_i;
      idx_a_q    <= col_q;
      flags_a_q  <= flags_d;
    end
    if (valid_a_q) begin
      line_mem[idx_a_q] <= wr_data;
    end
  end

  // shift window left and insert the new column
  always_comb begin
    win_d = win_q;
    if (valid_a_q) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r*3 + 0] = win_q[r*3 + 1];
        win_d[r*3 + 1] = win_q[r*3 + 2];
      end
      win_d[2] = older_pix;
      win_d[5] = newer_pix;
      win_d[8] = pix_a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  assign job_push_o  = valid_a_q;
  assign job_o.win   = win_d;
  assign job_o.flags = flags_a_q;

endmodule

>>> sv/gb3_back.sv
// back part: turns each job into zero to four blurred results
// depends on gb3_pkg; reads the job queue, writes the result queue
module gb3_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_empty_i,
  input  gb3_pkg::gb3_job_t                 job_i,
  output logic                              job_pop_o,
  input  logic [gb3_pkg::GB3_OUT_CNT_W-1:0] res_cnt_i,
  output logic                              res_push_o,
  output gb3_pkg::gb3_res_t                 res_o
);

  import gb3_pkg::*;

  // window element at row r, column c
  function automatic logic [7:0] px(gb3_win_t w, logic [1:0] r, logic [1:0] c);
    logic [3:0] idx;
    idx = ({2'b00, r} * 4'd3) + {2'b00, c};
    return w[idx];
  endfunction

  // weighted sum of one window row, weights 1 2 1
  function automatic logic [9:0] row_sum(gb3_win_t w, logic [1:0] r,
                                         logic [1:0] l, logic [1:0] c,
                                         logic [1:0] rt);
    return {2'b00, px(w, r, l)} + {1'b0, px(w, r, c), 1'b0} + {2'b00, px(w, r, rt)};
  endfunction

  logic [3:0] issued_q;
  logic [3:0] mask, remain, sel;
  logic       res_full, sel_r, sel_k, is_last;
  logic [1:0] t_row, m_row, b_row, l_col, c_col, r_col;
  logic [11:0] sum;

  assign res_full = (res_cnt_i == GB3_OUT_CNT_W'(GB3_OUT_DEPTH));

  // slots: 0 upper row left col, 1 upper row last col, 2 and 3 same for last row
  assign mask = {job_i.flags.last_row & job_i.flags.last_col,
                 job_i.flags.last_row & job_i.flags.j_ge1,
                 job_i.flags.i_ge1    & job_i.flags.last_col,
                 job_i.flags.i_ge1    & job_i.flags.j_ge1};
  assign remain  = mask & ~issued_q;
  assign sel     = remain & (~remain + 4'd1);
  assign sel_r   = sel[2] | sel[3];
  assign sel_k   = sel[1] | sel[3];
  assign is_last = ((remain & ~sel) == 4'd0);

  // window rows and columns of the chosen result
  always_comb begin
    if (sel_r) begin
      t_row = job_i.flags.i_ge1 ? 2'd1 : 2'd2;
      m_row = 2'd2;
      b_row = 2'd2;
    end else begin
      t_row = job_i.flags.i_ge2 ? 2'd0 : 2'd1;
      m_row = 2'd1;
      b_row = 2'd2;
    end
    if (sel_k) begin
      l_col = job_i.flags.j_ge1 ? 2'd1 : 2'd2;
      c_col = 2'd2;
      r_col = 2'd2;
    end else begin
      l_col = job_i.flags.j_ge2 ? 2'd0 : 2'd1;
      c_col = 2'd1;
      r_col = 2'd2;
    end
  end

  // 1 2 1 / 2 4 2 / 1 2 1 sum
  assign sum = {2'b00, row_sum(job_i.win, t_row, l_col, c_col, r_col)}
             + {1'b0, row_sum(job_i.win, m_row, l_col, c_col, r_col), 1'b0}
             + {2'b00, row_sum(job_i.win, b_row, l_col, c_col, r_col)};

  assign res_o.value = sum[11:4];
  assign res_o.last  = is_last;
  assign res_o.done  = sel[3];

  // one result per cycle if the result queue has room; job dropped with its last
  always_comb begin
    res_push_o = 1'b0;
    job_pop_o  = 1'b0;
    if (!job_empty_i) begin
      if (remain == 4'd0) begin
        job_pop_o = 1'b1;
      end else if (!res_full) begin
        res_push_o = 1'b1;
        job_pop_o  = is_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issued_q <= '0;
    end else if (job_pop_o) begin
      issued_q <= '0;
    end else if (res_push_o) begin
      issued_q <= issued_q | sel;
    end
  end

endmodule

>>> sv/gaussian_blur_3x3_core.sv
// 3x3 binomial blur core: one pixel accepted per cycle while each pixel gives at most
// one result and results are popped; a pixel with several results holds the back part
// until its last one is issued. Between accept and the result ports a result passes the
// line store read register, the job queue and the result queue.
// reset: position, queues and window clear, size returns to 640x480;
// line stores are not cleared and need no clearing pass.
module gaussian_blur_3x3_core #(
  parameter int MAX_WIDTH  = gb3_pkg::GB3_MAX_WIDTH,
  parameter int MAX_HEIGHT = gb3_pkg::GB3_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  gb3_pkg::gb3_reg_e              cfg_idx_i,
  input  logic [gb3_pkg::GB3_CFG_DW-1:0] cfg_data_i,
  input  logic                           push,
  input  logic [7:0]                     pixel_value_i,
  output logic                           full,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     blurred_value_o,
  output logic                           last_of_run_o,
  output logic                           frame_done_o
);

  import gb3_pkg::*;

  logic                     job_push, job_pop, job_empty;
  gb3_job_t                 job_in, job_out;
  logic [GB3_JOB_CNT_W-1:0] job_cnt;
  logic                     res_push;
  gb3_res_t                 res_in, res_out;
  logic [GB3_OUT_CNT_W-1:0] res_cnt;

  // front: position, line stores, window
  gb3_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .pixel_value_i(pixel_value_i),
    .full         (full),
    .job_cnt_i    (job_cnt),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  // queue between front and back
  gb3_fifo #(
    .WIDTH($bits(gb3_job_t)),
    .DEPTH(GB3_JOB_DEPTH)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_in),
    .pop_i  (job_pop),
    .rdata_o(job_out),
    .empty_o(job_empty),
    .count_o(job_cnt)
  );

  // back: result sequencing and the weighted sum
  gb3_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .res_cnt_i  (res_cnt),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // result queue toward the consumer
  gb3_fifo #(
    .WIDTH($bits(gb3_res_t)),
    .DEPTH(GB3_OUT_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .pop_i  (pop),
    .rdata_o(res_out),
    .empty_o(empty),
    .count_o(res_cnt)
  );

  assign blurred_value_o = res_out.value;
  assign last_of_run_o   = res_out.last;
  assign frame_done_o    = res_out.done;

endmodule

>>> verif/gaussian_blur_3x3_core_test.sv
// self-checking testbench of the 3x3 binomial blur core
// depends on gb3_pkg and gaussian_blur_3x3_core; holds its own blur predictor
`timescale 1ns / 100ps

module gaussian_blur_3x3_core_test;
  import gb3_pkg::*;

  localparam int MAX_W         = GB3_MAX_WIDTH;
  localparam int MAX_H         = GB3_MAX_HEIGHT;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1000000;

  // one blurred pixel as it leaves the core
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       done;
  } blur_px_t;

  localparam blur_px_t NO_RES = '0;

  typedef enum logic {
    STEP_PIXEL,
    STEP_REG
  } step_kind_e;

  // one directed step: a register write or a pixel, with an optional fixed result
  typedef struct packed {
    step_kind_e         kind;
    gb3_reg_e           reg_sel;
    logic [GB3_CFG_DW-1:0] data;
    logic [7:0]         pixel;
    logic               typed;
    blur_px_t           res;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  gb3_reg_e              cfg_idx_i;
  logic [GB3_CFG_DW-1:0] cfg_data_i;
  logic                  push;
  logic [7:0]            pixel_value_i;
  logic                  full;
  logic                  empty;
  logic                  pop;
  logic [7:0]            blurred_value_o;
  logic                  last_of_run_o;
  logic                  frame_done_o;

  // predictor state
  logic [GB3_W_REG_W-1:0] reg_width;
  logic [GB3_H_REG_W-1:0] reg_height;
  logic [7:0]             row_two_up [MAX_W];
  logic [7:0]             row_one_up [MAX_W];
  logic [7:0]             win [9];
  logic [10:0]            next_col;
  logic [11:0]            next_row;

  blur_px_t blurred_pixels_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int pixels_sent;
  int results_seen;
  int frames_done;
  int cfg_writes;
  int cycle_count;

  // directed steps
  stim_row_t directed_steps [$] = '{
    // first pixel at the reset size of 640 columns releases nothing
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h3C, 1'b0, NO_RES},
    // shrink mid-row: column 1 turns into the last of a one-row frame
    '{STEP_REG,   GB3_REG_WIDTH,  13'd2, 8'h00, 1'b0, NO_RES},
    '{STEP_REG,   GB3_REG_HEIGHT, 13'd1, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'hC3, 1'b0, NO_RES},
    // single-pixel frames give back the pixel itself
    '{STEP_REG,   GB3_REG_WIDTH,  13'd1, 8'h00, 1'b0, NO_RES},
    '{STEP_REG,   GB3_REG_HEIGHT, 13'd1, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    // zero size behaves as one
    '{STEP_REG,   GB3_REG_WIDTH,  13'd0, 8'h00, 1'b0, NO_RES},
    '{STEP_REG,   GB3_REG_HEIGHT, 13'd0, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'hA5, 1'b1, '{8'hA5, 1'b1, 1'b1}},
    // 3x2 checkerboard, last pixel releases four results
    '{STEP_REG,   GB3_REG_WIDTH,  13'd3, 8'h00, 1'b0, NO_RES},
    '{STEP_REG,   GB3_REG_HEIGHT, 13'd2, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'hFF, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'hFF, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'hFF, 1'b0, NO_RES},
    // one column, three rows
    '{STEP_REG,   GB3_REG_WIDTH,  13'd1, 8'h00, 1'b0, NO_RES},
    '{STEP_REG,   GB3_REG_HEIGHT, 13'd3, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h10, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h80, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'hFF, 1'b0, NO_RES},
    // one row, four columns
    '{STEP_REG,   GB3_REG_WIDTH,  13'd4, 8'h00, 1'b0, NO_RES},
    '{STEP_REG,   GB3_REG_HEIGHT, 13'd1, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'hFF, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h01, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'hFE, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h7F, 1'b0, NO_RES},
    // 4x4 frame resized mid-frame: column and row already past the new ends
    '{STEP_REG,   GB3_REG_WIDTH,  13'd4, 8'h00, 1'b0, NO_RES},
    '{STEP_REG,   GB3_REG_HEIGHT, 13'd4, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h11, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h22, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h33, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h44, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h55, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h66, 1'b0, NO_RES},
    '{STEP_REG,   GB3_REG_WIDTH,  13'd2, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h77, 1'b0, NO_RES},
    '{STEP_REG,   GB3_REG_HEIGHT, 13'd2, 8'h00, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h88, 1'b0, NO_RES},
    '{STEP_PIXEL, GB3_REG_WIDTH,  13'd0, 8'h99, 1'b0, NO_RES}
  };

  gaussian_blur_3x3_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .pixel_value_i   (pixel_value_i),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .blurred_value_o (blurred_value_o),
    .last_of_run_o   (last_of_run_o),
    .frame_done_o    (frame_done_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // (1,2,1) taps across three window rows, middle row weighted twice
  function automatic logic [7:0] weighted_sum(int row_t, int row_m, int row_b,
                                              int col_l, int col_c, int col_r);
    int s;
    int rr;
    s = 0;
    for (int q = 0; q < 3; q++) begin
      rr = (q == 0) ? row_t : ((q == 1) ? row_m : row_b);
      s += ((q == 1) ? 2 : 1) *
           (win[rr*3+col_l] + 2 * win[rr*3+col_c] + win[rr*3+col_r]);
    end
    return 8'(s >> 4);
  endfunction

  // advance the window by one pixel and list the blurred pixels it releases
  task automatic blur_next_pixel(input logic [7:0] px, output blur_px_t outs[$]);
    int w, h, i, j, r, k, row_t, row_m, row_b;
    bit last_col, last_row;
    blur_px_t res;
    outs = {};
    w = (reg_width == 0) ? 1 : ((reg_width > MAX_W) ? MAX_W : int'(reg_width));
    h = (reg_height == 0) ? 1 : ((reg_height > MAX_H) ? MAX_H : int'(reg_height));
    j = next_col;
    i = next_row;
    last_col = (j + 1 >= w);
    last_row = (i + 1 >= h);

    // shift left, new column from the line stores and the pixel
    for (r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = row_two_up[j];
    win[5] = row_one_up[j];
    win[8] = px;
    row_two_up[j] = row_one_up[j];
    row_one_up[j] = px;

    // row above first, then the last row itself; left column, then own column
    for (r = 0; r < 2; r++) begin
      if (r == 0) begin
        if (i < 1) continue;
        row_t = (i >= 2) ? 0 : 1;
        row_m = 1;
        row_b = 2;
      end else begin
        if (!last_row) continue;
        row_t = (i >= 1) ? 1 : 2;
        row_m = 2;
        row_b = 2;
      end
      for (k = 0; k < 2; k++) begin
        if (k == 0) begin
          if (j < 1) continue;
          res.value = weighted_sum(row_t, row_m, row_b, (j >= 2) ? 0 : 1, 1, 2);
          res.done  = 1'b0;
        end else begin
          if (!last_col) continue;
          res.value = weighted_sum(row_t, row_m, row_b, (j >= 1) ? 1 : 2, 2, 2);
          res.done  = (r == 1);
        end
        res.last = 1'b0;
        outs.push_back(res);
      end
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;

    // raster position, wrapping to a new frame after the final pixel
    if (last_col) begin
      next_col = '0;
      next_row = last_row ? '0 : next_row + 1'b1;
    end else begin
      next_col = next_col + 1'b1;
    end
  endtask

  // drop push and wait until every blurred pixel is out and the core is quiet
  task automatic wait_block_idle();
    push <= 1'b0;
    while (blurred_pixels_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // frame size write, only with the core idle
  task automatic write_size(input gb3_reg_e sel, input int data);
    wait_block_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= GB3_CFG_DW'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == GB3_REG_WIDTH) reg_width = GB3_W_REG_W'(data);
    else reg_height = GB3_H_REG_W'(data);
    cfg_writes++;
  endtask

  // one pixel request, with random idle cycles ahead of it
  task automatic feed_pixel(input logic [7:0] px, input bit typed, input blur_px_t typed_res);
    blur_px_t outs [$];
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    pixel_value_i <= px;
    do @(posedge clk_i); while (full);
    blur_next_pixel(px, outs);
    if (typed) blurred_pixels_q.push_back(typed_res);
    else foreach (outs[q]) blurred_pixels_q.push_back(outs[q]);
    pixels_sent++;
  endtask

  // whole frame, optionally resized partway through
  task automatic run_frame(input int w, input int h, input bit mid_change, input bit extreme);
    int fed;
    int change_at;
    logic [7:0] px;
    fed = 0;
    change_at = $urandom_range(1, 12);
    write_size(GB3_REG_WIDTH, w);
    write_size(GB3_REG_HEIGHT, h);
    do begin
      px = extreme ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom_range(255));
      feed_pixel(px, 1'b0, NO_RES);
      fed++;
      if (mid_change && fed == change_at && !(next_col == 0 && next_row == 0)) begin
        if ($urandom_range(1)) write_size(GB3_REG_WIDTH, $urandom_range(0, 10));
        else write_size(GB3_REG_HEIGHT, $urandom_range(0, 6));
      end
    end while (!(next_col == 0 && next_row == 0));
    frames_done++;
  endtask

  // small frames of random size and content until enough pixels went in
  task automatic run_random_frames(input int count);
    int mark, pick, w, h;
    mark = pixels_sent;
    while (pixels_sent - mark < count) begin
      pick = $urandom_range(99);
      w = (pick < 5) ? 0 : ((pick < 75) ? $urandom_range(1, 8) : $urandom_range(9, 24));
      h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
      run_frame(w, h, $urandom_range(5) == 0, $urandom_range(4) == 0);
    end
  endtask

  // result side: random pop, compare each accepted result with the oldest prediction
  initial begin : result_side
    blur_px_t want;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        results_seen++;
        if (blurred_pixels_q.size() == 0) begin
          $display("%0t: result with nothing pending: value %h last %b done %b",
                   $time, blurred_value_o, last_of_run_o, frame_done_o);
          error_count++;
        end else begin
          want = blurred_pixels_q.pop_front();
          if (blurred_value_o !== want.value) begin
            $display("%0t: blurred_value expected %h actual %h",
                     $time, want.value, blurred_value_o);
            error_count++;
          end
          if (last_of_run_o !== want.last) begin
            $display("%0t: last_of_run expected %b actual %b",
                     $time, want.last, last_of_run_o);
            error_count++;
          end
          if (frame_done_o !== want.done) begin
            $display("%0t: frame_done expected %b actual %b",
                     $time, want.done, frame_done_o);
            error_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gaussian_blur_3x3_core regression: fail");
      $finish;
    end
  end

  // stimulus
  initial begin : pixel_side
    stim_row_t row;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= GB3_REG_WIDTH;
    cfg_data_i    <= '0;
    push          <= 1'b0;
    pixel_value_i <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_width  = GB3_W_REG_W'(GB3_RST_WIDTH);
    reg_height = GB3_H_REG_W'(GB3_RST_HEIGHT);
    for (int n = 0; n < MAX_W; n++) begin
      row_two_up[n] = '0;
      row_one_up[n] = '0;
    end
    for (int n = 0; n < 9; n++) win[n] = '0;
    next_col = '0;
    next_row = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed steps, sender lightly idled, receiver idle about half the time
    send_idle_pct = 11;
    recv_idle_pct = 54;
    foreach (directed_steps[n]) begin
      row = directed_steps[n];
      if (row.kind == STEP_REG) write_size(row.reg_sel, row.data);
      else feed_pixel(row.pixel, row.typed, row.res);
    end

    // widest random frame first so every line store entry in use holds a written pixel
    run_frame(24, 2, 1'b0, 1'b0);
    run_random_frames(100);

    // sender mostly idle, receiver rarely stalling
    send_idle_pct = 54;
    recv_idle_pct = 11;
    run_random_frames(100);

    // full rate: oversize sizes cut short mid-frame, then more small frames
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_size(GB3_REG_WIDTH, 2050);
    write_size(GB3_REG_HEIGHT, 4097);
    repeat (6) feed_pixel(8'($urandom_range(255)), 1'b0, NO_RES);
    write_size(GB3_REG_WIDTH, 3);
    write_size(GB3_REG_HEIGHT, 2);
    do feed_pixel(8'($urandom_range(255)), 1'b0, NO_RES);
    while (!(next_col == 0 && next_row == 0));
    frames_done++;
    run_random_frames(100);

    wait_block_idle();
    $display("run covered %0d pixels in %0d frames, %0d results, %0d size writes",
             pixels_sent, frames_done, results_seen, cfg_writes);
    $display("sizes from zero to 24x6, oversize writes, mid-frame resizes, three idle patterns");
    if (error_count == 0) begin
      $display("gaussian_blur_3x3_core regression: pass");
    end else begin
      $display("gaussian_blur_3x3_core regression: fail");
    end
    $finish;
  end

endmodule
